// ===== rtl/klpd_pkg.sv =====
package klpd_pkg;

  // Matrix and tick defaults
  localparam int ROWS_DEF      = 3;
  localparam int COLS_DEF      = 7;
  localparam int TICK_BITS_DEF = 32;

  // Field widths
  localparam int ROW_W = 2;
  localparam int COL_W = 3;
  localparam int NOW_W = 32;
  localparam int LPT_W = 16;

  localparam logic [LPT_W-1:0] LPT_RESET = 16'd60;

  // Slave tdata: row, col, pressed, now (from bit 0 up)
  localparam int IN_ROW_LSB     = 0;
  localparam int IN_COL_LSB     = IN_ROW_LSB + ROW_W;
  localparam int IN_PRESSED_BIT = IN_COL_LSB + COL_W;
  localparam int IN_NOW_LSB     = IN_PRESSED_BIT + 1;
  localparam int IN_BITS        = IN_NOW_LSB + NOW_W;
  localparam int IN_TDATA_W     = ((IN_BITS + 7) / 8) * 8;

  // Master tdata: row, col (from bit 0 up); kind travels on tuser
  localparam int OUT_ROW_LSB = 0;
  localparam int OUT_COL_LSB = OUT_ROW_LSB + ROW_W;
  localparam int OUT_BITS    = OUT_COL_LSB + COL_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_TIMING   = 2'd1,
    PH_REPORTED = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   emit;
    logic   kind;
  } upd_t;

endpackage

// ===== rtl/keypad_long_press_detector.sv =====
// Channel   Dir  Payload (bit 0 up)                                  Transaction
// s_axis    in   tdata: key_row, key_col, is_pressed, now_ticks       tvalid & tready
// m_axis    out  tdata: event_row, event_col; tuser: event_kind       tvalid & tready
// cfg       in   wdata: long_press_ticks                              we
//
// One key sample per cycle. Each sample is a read-modify-write of its key entry in the
// key memory: read at acceptance, update and write-back as the stage advances,
// result in the output register after that write-back edge. A back-to-back sample of
// the same key takes the written entry from the write port straight into the read
// register. Reset clears one valid bit per key at once; no clearing pass is needed.
// A stalled output holds the update stage, which drops s_axis_tready_o.
module keypad_long_press_detector #(
  parameter int ROWS      = klpd_pkg::ROWS_DEF,
  parameter int COLS      = klpd_pkg::COLS_DEF,
  parameter int TICK_BITS = klpd_pkg::TICK_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // key_row[1:0], key_col[4:2], is_pressed[5], now_ticks[37:6], zero pad
  input  logic [klpd_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // event_row[1:0], event_col[4:2], zero pad
  output logic [klpd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // event_kind[0]
  output logic                              m_axis_tuser_o,
  input  logic                              cfg_we_i,
  input  logic [klpd_pkg::LPT_W-1:0]        cfg_wdata_i
);

  localparam int NKEYS = ROWS * COLS;
  localparam int KEY_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  // Input unpack
  logic [klpd_pkg::ROW_W-1:0] in_row;
  logic [klpd_pkg::COL_W-1:0] in_col;
  logic                       in_pressed;
  logic [klpd_pkg::NOW_W-1:0] in_now;
  logic [63:0]                now_ext;
  logic                       in_range;
  logic [KEY_W-1:0]           in_idx;
  logic                       accept;

  assign in_row     = s_axis_tdata_i[klpd_pkg::IN_ROW_LSB +: klpd_pkg::ROW_W];
  assign in_col     = s_axis_tdata_i[klpd_pkg::IN_COL_LSB +: klpd_pkg::COL_W];
  assign in_pressed = s_axis_tdata_i[klpd_pkg::IN_PRESSED_BIT];
  assign in_now     = s_axis_tdata_i[klpd_pkg::IN_NOW_LSB +: klpd_pkg::NOW_W];
  assign now_ext    = 64'(in_now);

  assign in_range = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
  assign in_idx   = in_range ? KEY_W'(32'(in_row) * 32'(COLS) + 32'(in_col)) : '0;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration
  logic [klpd_pkg::LPT_W-1:0] lpt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpt_q <= klpd_pkg::LPT_RESET;
    end else if (cfg_we_i) begin
      lpt_q <= cfg_wdata_i;
    end
  end

  // Update stage
  logic                       s1_valid_q;
  logic [klpd_pkg::ROW_W-1:0] s1_row_q;
  logic [klpd_pkg::COL_W-1:0] s1_col_q;
  logic                       s1_pressed_q;
  logic [TICK_BITS-1:0]       s1_now_q;
  logic                       s1_range_q;
  logic [KEY_W-1:0]           s1_idx_q;
  logic                       s1_adv;
  logic                       wr_en;

  logic                       out_valid_q;

  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign wr_en           = s1_adv && s1_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q     <= in_row;
      s1_col_q     <= in_col;
      s1_pressed_q <= in_pressed;
      s1_now_q     <= now_ext[TICK_BITS-1:0];
      s1_range_q   <= in_range;
      s1_idx_q     <= in_idx;
    end
  end

  // Key memory
  klpd_pkg::phase_e     phase_mem_q [NKEYS];
  logic [TICK_BITS-1:0] dl_mem_q    [NKEYS];
  logic [NKEYS-1:0]     valid_q;

  klpd_pkg::phase_e     rd_phase_q;
  logic [TICK_BITS-1:0] rd_dl_q;
  logic                 rd_valid_q;
  logic                 wr_hit;

  klpd_pkg::phase_e     cur_phase;
  logic [TICK_BITS-1:0] cur_dl;
  klpd_pkg::upd_t       upd;
  logic [TICK_BITS-1:0] upd_dl;

  assign wr_hit = wr_en && (s1_idx_q == in_idx);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      phase_mem_q[s1_idx_q] <= upd.phase;
      dl_mem_q[s1_idx_q]    <= upd_dl;
    end
    if (accept) begin
      // Bypass the entry being written this edge
      if (wr_hit) begin
        rd_phase_q <= upd.phase;
        rd_dl_q    <= upd_dl;
        rd_valid_q <= 1'b1;
      end else begin
        rd_phase_q <= phase_mem_q[in_idx];
        rd_dl_q    <= dl_mem_q[in_idx];
        rd_valid_q <= valid_q[in_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[s1_idx_q] <= 1'b1;
    end
  end

  assign cur_phase = rd_valid_q ? rd_phase_q : klpd_pkg::PH_IDLE;
  assign cur_dl    = rd_valid_q ? rd_dl_q : '0;

  klpd_update #(
    .TICK_BITS (TICK_BITS)
  ) u_update (
    .phase_i    (cur_phase),
    .deadline_i (cur_dl),
    .now_i      (s1_now_q),
    .pressed_i  (s1_pressed_q),
    .lpt_i      (lpt_q),
    .ctl_o      (upd),
    .deadline_o (upd_dl)
  );

  // Output register
  logic [klpd_pkg::ROW_W-1:0] out_row_q;
  logic [klpd_pkg::COL_W-1:0] out_col_q;
  logic                       out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_range_q && upd.emit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_row_q  <= s1_row_q;
      out_col_q  <= s1_col_q;
      out_kind_q <= upd.kind;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = klpd_pkg::OUT_TDATA_W'({out_col_q, out_row_q});
  assign m_axis_tuser_o  = out_kind_q;

endmodule

// ===== rtl/klpd_update.sv =====
module klpd_update #(
  parameter int TICK_BITS = klpd_pkg::TICK_BITS_DEF
) (
  input  klpd_pkg::phase_e             phase_i,
  input  logic [TICK_BITS-1:0]         deadline_i,
  input  logic [TICK_BITS-1:0]         now_i,
  input  logic                         pressed_i,
  input  logic [klpd_pkg::LPT_W-1:0]   lpt_i,
  output klpd_pkg::upd_t               ctl_o,
  output logic [TICK_BITS-1:0]         deadline_o
);

  logic [TICK_BITS-1:0] diff;
  logic                 after;

  // Wrap-safe: now is past the deadline when deadline - now is negative
  assign diff  = deadline_i - now_i;
  assign after = diff[TICK_BITS-1];

  always_comb begin
    ctl_o.phase = klpd_pkg::PH_IDLE;
    ctl_o.emit  = 1'b0;
    ctl_o.kind  = klpd_pkg::KIND_SHORT;
    deadline_o  = deadline_i;
    case (phase_i)
      klpd_pkg::PH_TIMING: begin
        if (pressed_i) begin
          if (after) begin
            ctl_o.phase = klpd_pkg::PH_REPORTED;
            ctl_o.emit  = 1'b1;
            ctl_o.kind  = klpd_pkg::KIND_LONG;
          end else begin
            ctl_o.phase = klpd_pkg::PH_TIMING;
          end
        end else begin
          ctl_o.emit = 1'b1;
          ctl_o.kind = after ? klpd_pkg::KIND_LONG : klpd_pkg::KIND_SHORT;
        end
      end
      klpd_pkg::PH_REPORTED: begin
        // Release from reported is silent
        ctl_o.phase = pressed_i ? klpd_pkg::PH_REPORTED : klpd_pkg::PH_IDLE;
      end
      default: begin
        if (pressed_i) begin
          ctl_o.phase = klpd_pkg::PH_TIMING;
          deadline_o  = now_i + TICK_BITS'(lpt_i);
        end
      end
    endcase
  end

endmodule

// ===== rtl/klpd_checker.sv =====
module klpd_checker #(
  parameter int ROWS = klpd_pkg::ROWS_DEF,
  parameter int COLS = klpd_pkg::COLS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [klpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);

  logic [klpd_pkg::ROW_W-1:0] ev_row;
  logic [klpd_pkg::COL_W-1:0] ev_col;

  assign ev_row = m_axis_tdata_o[klpd_pkg::OUT_ROW_LSB +: klpd_pkg::ROW_W];
  assign ev_col = m_axis_tdata_o[klpd_pkg::OUT_COL_LSB +: klpd_pkg::COL_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("event transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("event payload changed while stalled");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> 32'(ev_row) < ROWS)
    else $error("event for a row outside the matrix");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> 32'(ev_col) < COLS)
    else $error("event for a column outside the matrix");

endmodule

bind keypad_long_press_detector klpd_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_klpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== verif/klpd_event_checker.sv =====
`timescale 1ns / 1ps
module klpd_event_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [klpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  input  logic [klpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                             m_axis_tuser_i,
  input  logic                             cfg_we_i,
  input  logic [klpd_pkg::LPT_W-1:0]       cfg_wdata_i,
  output int                               pending_o,
  output int                               errors_o
);

  localparam int KEYS = klpd_pkg::ROWS_DEF * klpd_pkg::COLS_DEF;

  typedef struct packed {
    logic [klpd_pkg::ROW_W-1:0] row;
    logic [klpd_pkg::COL_W-1:0] col;
    logic                       kind;
  } key_event_t;

  klpd_pkg::phase_e           key_phase_q [KEYS];
  logic [klpd_pkg::NOW_W-1:0] key_due_q   [KEYS];
  logic [klpd_pkg::LPT_W-1:0] hold_ticks_q;
  key_event_t                 events_due [$];
  int                         errors_q = 0;

  assign errors_o = errors_q;

  // Wrap-safe: now is past due when (due - now) is negative as a signed tick count.
  function automatic logic tick_passed(input logic [klpd_pkg::NOW_W-1:0] now,
                                       input logic [klpd_pkg::NOW_W-1:0] due);
    logic [klpd_pkg::NOW_W-1:0] diff;
    diff = due - now;
    return diff[klpd_pkg::NOW_W-1];
  endfunction

  task automatic queue_event(input logic [klpd_pkg::ROW_W-1:0] row,
                             input logic [klpd_pkg::COL_W-1:0] col,
                             input logic kind);
    key_event_t ev;
    ev.row  = row;
    ev.col  = col;
    ev.kind = kind;
    events_due.push_back(ev);
  endtask

  task automatic predict_sample(input logic [klpd_pkg::IN_TDATA_W-1:0] data);
    logic [klpd_pkg::ROW_W-1:0] row;
    logic [klpd_pkg::COL_W-1:0] col;
    logic                       pressed;
    logic [klpd_pkg::NOW_W-1:0] now;
    int                         idx;
    klpd_pkg::phase_e           ph;
    row     = data[klpd_pkg::IN_ROW_LSB +: klpd_pkg::ROW_W];
    col     = data[klpd_pkg::IN_COL_LSB +: klpd_pkg::COL_W];
    pressed = data[klpd_pkg::IN_PRESSED_BIT];
    now     = data[klpd_pkg::IN_NOW_LSB +: klpd_pkg::NOW_W];
    // Drop samples outside the matrix
    if (int'(row) >= klpd_pkg::ROWS_DEF || int'(col) >= klpd_pkg::COLS_DEF) return;
    idx = int'(row) * klpd_pkg::COLS_DEF + int'(col);
    ph  = key_phase_q[idx];
    if (pressed) begin
      if (ph == klpd_pkg::PH_IDLE) begin
        key_due_q[idx]   = now + klpd_pkg::NOW_W'(hold_ticks_q);
        key_phase_q[idx] = klpd_pkg::PH_TIMING;
      end else if (ph == klpd_pkg::PH_TIMING && tick_passed(now, key_due_q[idx])) begin
        key_phase_q[idx] = klpd_pkg::PH_REPORTED;
        queue_event(row, col, klpd_pkg::KIND_LONG);
      end
    end else begin
      key_phase_q[idx] = klpd_pkg::PH_IDLE;
      if (ph == klpd_pkg::PH_TIMING)
        queue_event(row, col, tick_passed(now, key_due_q[idx]) ?
                    klpd_pkg::KIND_LONG : klpd_pkg::KIND_SHORT);
    end
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors_q++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_event(input logic [klpd_pkg::OUT_TDATA_W-1:0] data, input logic kind);
    key_event_t want;
    if (events_due.size() == 0) begin
      errors_q++;
      $display("%0t: unexpected event, expected none actual row %0d col %0d kind %0d",
               $time, data[klpd_pkg::OUT_ROW_LSB +: klpd_pkg::ROW_W],
               data[klpd_pkg::OUT_COL_LSB +: klpd_pkg::COL_W], kind);
      return;
    end
    want = events_due.pop_front();
    cmp_field("event_row", 8'(want.row),
              8'(data[klpd_pkg::OUT_ROW_LSB +: klpd_pkg::ROW_W]));
    cmp_field("event_col", 8'(want.col),
              8'(data[klpd_pkg::OUT_COL_LSB +: klpd_pkg::COL_W]));
    cmp_field("event_kind", 8'(want.kind), 8'(kind));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEYS; k++) begin
        key_phase_q[k] = klpd_pkg::PH_IDLE;
        key_due_q[k]   = '0;
      end
      hold_ticks_q = klpd_pkg::LPT_RESET;
      events_due.delete();
      pending_o <= 0;
    end else begin
      // Results in flight come from earlier samples: check before predicting
      if (m_axis_tvalid_i && m_axis_tready_i) check_event(m_axis_tdata_i, m_axis_tuser_i);
      if (s_axis_tvalid_i && s_axis_tready_i) predict_sample(s_axis_tdata_i);
      if (cfg_we_i) hold_ticks_q = cfg_wdata_i;
      pending_o <= events_due.size();
    end
  end

endmodule

// ===== verif/tb_keypad_long_press_detector.sv =====
`timescale 1ns / 1ps
module tb_keypad_long_press_detector;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [klpd_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [klpd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tuser;
  logic                             cfg_we    = 1'b0;
  logic [klpd_pkg::LPT_W-1:0]       cfg_wdata = klpd_pkg::LPT_RESET;

  int          pending;
  int          errors;
  int          cycle_cnt   = 0;
  int          sent_items  = 0;
  int          burst_left  = 0;
  bit          valid_up    = 1'b0;
  logic [31:0] tick_now;

  always #4 clk = ~clk;

  keypad_long_press_detector dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  klpd_event_checker events_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Change tvalid only when it differs, so one step never sees two writes
  task automatic set_valid(input bit v);
    if (valid_up != v) s_tvalid <= v;
    valid_up = v;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 16);
    case ($urandom_range(0, 5))
      0, 1:    gap = 0;
      2:       gap = $urandom_range(10, 30);
      default: gap = $urandom_range(1, 6);
    endcase
    if (gap > 0) begin
      set_valid(1'b0);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_sample(input logic [klpd_pkg::ROW_W-1:0] row,
                            input logic [klpd_pkg::COL_W-1:0] col,
                            input logic pressed, input logic [klpd_pkg::NOW_W-1:0] now);
    logic [klpd_pkg::IN_TDATA_W-1:0] word;
    word = '0;
    word[klpd_pkg::IN_ROW_LSB +: klpd_pkg::ROW_W] = row;
    word[klpd_pkg::IN_COL_LSB +: klpd_pkg::COL_W] = col;
    word[klpd_pkg::IN_PRESSED_BIT]                = pressed;
    word[klpd_pkg::IN_NOW_LSB +: klpd_pkg::NOW_W] = now;
    s_tdata <= word;
    set_valid(1'b1);
    do @(posedge clk); while (!s_tready);
    sent_items++;
    pace_sender();
  endtask

  // Wait for every expected event, then let samples without events leave the pipe
  task automatic drain_events();
    set_valid(1'b0);
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_hold_ticks(input logic [klpd_pkg::LPT_W-1:0] ticks);
    drain_events();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly a few hot keys so press, hold and release sequences form per key
  task automatic run_random(input int count, input int unsigned step_max);
    logic [klpd_pkg::ROW_W-1:0] hot_row [3];
    logic [klpd_pkg::COL_W-1:0] hot_col [3];
    logic [klpd_pkg::ROW_W-1:0] row;
    logic [klpd_pkg::COL_W-1:0] col;
    int                         slot;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        for (int p = 0; p < 3; p++) begin
          hot_row[p] = klpd_pkg::ROW_W'($urandom_range(0, klpd_pkg::ROWS_DEF - 1));
          hot_col[p] = klpd_pkg::COL_W'($urandom_range(0, klpd_pkg::COLS_DEF - 1));
        end
      end
      slot = $urandom_range(0, 2);
      row  = hot_row[slot];
      col  = hot_col[slot];
      if ($urandom_range(0, 99) < 12) begin
        row = klpd_pkg::ROW_W'($urandom_range(0, klpd_pkg::ROWS_DEF - 1));
        col = klpd_pkg::COL_W'($urandom_range(0, klpd_pkg::COLS_DEF - 1));
      end
      if ($urandom_range(0, 99) < 5) begin
        row = klpd_pkg::ROW_W'($urandom_range(0, 3));
        col = klpd_pkg::COL_W'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 99) < 2) tick_now = $urandom();
      else tick_now = tick_now + $urandom_range(0, step_max);
      put_sample(row, col, $urandom_range(0, 99) < 60, tick_now);
    end
  endtask

  // Receiver: stall patterns of its own, plus one long hold-off to back up the block
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && sent_items >= 300) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      for (int i = 0; i < span; i++) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          2:       m_tready <= (i % 4 == 0);
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [klpd_pkg::LPT_W-1:0] mid_ticks;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset hold time of 60 ticks
    put_sample(2'd0, 3'd0, 1'b1, 32'd1000);
    put_sample(2'd0, 3'd0, 1'b1, 32'd1060);   // on the deadline: not long yet
    put_sample(2'd0, 3'd0, 1'b1, 32'd1061);   // long press
    put_sample(2'd0, 3'd0, 1'b1, 32'd1200);   // already reported: silent
    put_sample(2'd0, 3'd0, 1'b0, 32'd1201);   // release after report: silent
    put_sample(2'd0, 3'd0, 1'b0, 32'd1202);   // release of an idle key
    put_sample(2'd2, 3'd6, 1'b1, 32'd2000);
    put_sample(2'd2, 3'd6, 1'b0, 32'd2010);   // short
    put_sample(2'd2, 3'd6, 1'b1, 32'd2020);
    put_sample(2'd2, 3'd6, 1'b0, 32'd2081);   // long on release
    put_sample(2'd1, 3'd3, 1'b1, 32'hFFFF_FFF0);
    put_sample(2'd1, 3'd3, 1'b1, 32'h0000_0010);  // deadline wrapped past zero
    put_sample(2'd1, 3'd3, 1'b1, 32'h0000_002D);
    put_sample(2'd1, 3'd3, 1'b0, 32'hFFFF_FFFF);
    put_sample(2'd3, 3'd0, 1'b1, 32'd5);      // outside the matrix
    put_sample(2'd0, 3'd7, 1'b1, 32'd6);
    put_sample(2'd3, 3'd7, 1'b0, 32'd7);
    put_sample(2'd1, 3'd1, 1'b1, 32'd0);
    put_sample(2'd1, 3'd1, 1'b0, 32'd0);
    put_sample(2'd1, 3'd5, 1'b1, 32'hFFFF_FFFF);
    put_sample(2'd1, 3'd5, 1'b0, 32'h0000_003B);

    tick_now = 32'd5000;
    run_random(130, 16);

    write_hold_ticks(16'd1);
    run_random(130, 1);

    write_hold_ticks(16'hFFFF);
    run_random(130, 16384);

    // Zero hold time: long from the next tick after the press
    write_hold_ticks(16'd0);
    put_sample(2'd2, 3'd2, 1'b1, 32'd500);
    put_sample(2'd2, 3'd2, 1'b1, 32'd500);
    put_sample(2'd2, 3'd2, 1'b1, 32'd501);
    put_sample(2'd2, 3'd2, 1'b0, 32'd502);

    mid_ticks = klpd_pkg::LPT_W'($urandom_range(2, 400));
    write_hold_ticks(mid_ticks);
    run_random(130, 32'(mid_ticks) / 4 + 1);

    drain_events();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
